[sv/chce_pkg.sv]
`default_nettype none
package chce_pkg;

	localparam int T_W     = 18;
	localparam int COORD_W = 32;
	localparam int FRAC_W  = 16;
	localparam int ACC_W   = 38;
	localparam int PROD_W  = ACC_W + T_W;
	localparam int PADDR_W = 5;
	localparam int PDATA_W = 32;
	localparam int NUM_REGS = 8;
	localparam int NUM_AXES = 2;

	typedef logic signed [T_W-1:0]     t_t;
	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [ACC_W-1:0]   acc_t;
	typedef logic signed [PROD_W-1:0]  prod_t;

	typedef enum logic [2:0] {
		REG_START_X     = 3'd0,
		REG_START_Y     = 3'd1,
		REG_START_TAN_X = 3'd2,
		REG_START_TAN_Y = 3'd3,
		REG_END_X       = 3'd4,
		REG_END_Y       = 3'd5,
		REG_END_TAN_X   = 3'd6,
		REG_END_TAN_Y   = 3'd7
	} cfg_idx_t;

	localparam t_t     T_ONE      = t_t'(1 << FRAC_W);
	localparam prod_t  ROUND_HALF = prod_t'(1 << (FRAC_W - 1));
	localparam coord_t COORD_MAX  = {1'b0, {(COORD_W-1){1'b1}}};
	localparam coord_t COORD_MIN  = {1'b1, {(COORD_W-1){1'b0}}};

endpackage
`default_nettype wire

[sv/chce_if.sv]
`default_nettype none
interface chce_sample_if;
	logic            valid;
	logic            ready;
	chce_pkg::t_t    param_t;

	modport source (output valid, output param_t, input ready);
	modport sink   (input valid, input param_t, output ready);
endinterface

interface chce_point_if;
	logic             valid;
	logic             ready;
	chce_pkg::coord_t point_x;
	chce_pkg::coord_t point_y;

	modport source (output valid, output point_x, output point_y, input ready);
	modport sink   (input valid, input point_x, input point_y, output ready);
endinterface
`default_nettype wire

[sv/cubic_hermite_curve_eval.sv]
// Samples pass registers s1 to s7 to the output. Throughput: one sample
// per cycle unless the output stalls; three multiply/round stage pairs per
// axis (two 38x18 multipliers per multiply stage) set the depth.
// Reset: registers and coefficients clear to zero, the pipeline empties.
// Coefficients are registered from the register file and follow a write in the cycle after it.
`default_nettype none
module cubic_hermite_curve_eval (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [chce_pkg::PADDR_W-1:0]  paddr,
	input  wire logic [chce_pkg::PDATA_W-1:0]  pwdata,
	output logic      [chce_pkg::PDATA_W-1:0]  prdata,
	output logic                               pready,
	chce_sample_if.sink                        sample,
	chce_point_if.source                       point
);
	import chce_pkg::*;

	coord_t   cfg_q [NUM_REGS];
	acc_t     coef_a_q [NUM_AXES];
	acc_t     coef_b_q [NUM_AXES];
	acc_t     coef_c_q [NUM_AXES];
	acc_t     coef_d_q [NUM_AXES];
	cfg_idx_t waddr;

	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6, valid_s7;
	logic en_1, en_2, en_3, en_4, en_5, en_6, en_7;
	t_t    t_s1, t_s2, t_s3, t_s4, t_s5;
	prod_t prod_s2 [NUM_AXES];
	acc_t  acc_s3  [NUM_AXES];
	prod_t prod_s4 [NUM_AXES];
	acc_t  acc_s5  [NUM_AXES];
	prod_t prod_s6 [NUM_AXES];
	coord_t pt_s7  [NUM_AXES];
	t_t    t_clamp;

	function automatic acc_t form_a(coord_t p1, coord_t t1, coord_t p2, coord_t t2);
		acc_t e1, et1, e2, et2;
		e1  = acc_t'(p1);
		et1 = acc_t'(t1);
		e2  = acc_t'(p2);
		et2 = acc_t'(t2);
		return (e1 <<< 1) + et1 + et2 - (e2 <<< 1);
	endfunction

	function automatic acc_t form_b(coord_t p1, coord_t t1, coord_t p2, coord_t t2);
		acc_t e1, et1, e2, et2;
		e1  = acc_t'(p1);
		et1 = acc_t'(t1);
		e2  = acc_t'(p2);
		et2 = acc_t'(t2);
		return (e2 <<< 1) + e2 - (e1 <<< 1) - e1 - (et1 <<< 1) - et2;
	endfunction

	function automatic acc_t round_q16(prod_t p);
		prod_t r;
		r = (p + ROUND_HALF) >>> FRAC_W;
		return acc_t'(r);
	endfunction

	function automatic coord_t sat32(acc_t v);
		coord_t r;
		if (v > acc_t'(COORD_MAX)) begin
			r = COORD_MAX;
		end else if (v < acc_t'(COORD_MIN)) begin
			r = COORD_MIN;
		end else begin
			r = coord_t'(v);
		end
		return r;
	endfunction

	// register file
	assign pready = 1'b1;
	assign waddr  = cfg_idx_t'(paddr[PADDR_W-1:2]);
	assign prdata = PDATA_W'(cfg_q[paddr[PADDR_W-1:2]]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) cfg_q[i] <= '0;
		end else if (psel && penable && pwrite && pready) begin
			cfg_q[waddr] <= coord_t'(pwdata);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int a = 0; a < NUM_AXES; a++) begin
				coef_a_q[a] <= '0;
				coef_b_q[a] <= '0;
				coef_c_q[a] <= '0;
				coef_d_q[a] <= '0;
			end
		end else begin
			coef_a_q[0] <= form_a(cfg_q[REG_START_X], cfg_q[REG_START_TAN_X],
				cfg_q[REG_END_X], cfg_q[REG_END_TAN_X]);
			coef_b_q[0] <= form_b(cfg_q[REG_START_X], cfg_q[REG_START_TAN_X],
				cfg_q[REG_END_X], cfg_q[REG_END_TAN_X]);
			coef_c_q[0] <= acc_t'(cfg_q[REG_START_TAN_X]);
			coef_d_q[0] <= acc_t'(cfg_q[REG_START_X]);
			coef_a_q[1] <= form_a(cfg_q[REG_START_Y], cfg_q[REG_START_TAN_Y],
				cfg_q[REG_END_Y], cfg_q[REG_END_TAN_Y]);
			coef_b_q[1] <= form_b(cfg_q[REG_START_Y], cfg_q[REG_START_TAN_Y],
				cfg_q[REG_END_Y], cfg_q[REG_END_TAN_Y]);
			coef_c_q[1] <= acc_t'(cfg_q[REG_START_TAN_Y]);
			coef_d_q[1] <= acc_t'(cfg_q[REG_START_Y]);
		end
	end

	// stall chain
	assign en_7 = !valid_s7 || point.ready;
	assign en_6 = !valid_s6 || en_7;
	assign en_5 = !valid_s5 || en_6;
	assign en_4 = !valid_s4 || en_5;
	assign en_3 = !valid_s3 || en_4;
	assign en_2 = !valid_s2 || en_3;
	assign en_1 = !valid_s1 || en_2;
	assign sample.ready = en_1;

	always_comb begin
		if (sample.param_t[T_W-1]) begin
			t_clamp = '0;
		end else if (sample.param_t > T_ONE) begin
			t_clamp = T_ONE;
		end else begin
			t_clamp = sample.param_t;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
		end else begin
			if (en_1) valid_s1 <= sample.valid;
			if (en_2) valid_s2 <= valid_s1;
			if (en_3) valid_s3 <= valid_s2;
			if (en_4) valid_s4 <= valid_s3;
			if (en_5) valid_s5 <= valid_s4;
			if (en_6) valid_s6 <= valid_s5;
			if (en_7) valid_s7 <= valid_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en_1) t_s1 <= t_clamp;
		if (en_2) t_s2 <= t_s1;
		if (en_3) t_s3 <= t_s2;
		if (en_4) t_s4 <= t_s3;
		if (en_5) t_s5 <= t_s4;
		for (int a = 0; a < NUM_AXES; a++) begin
			if (en_2) prod_s2[a] <= prod_t'(coef_a_q[a]) * prod_t'(t_s1);
			if (en_3) acc_s3[a]  <= round_q16(prod_s2[a]) + coef_b_q[a];
			if (en_4) prod_s4[a] <= prod_t'(acc_s3[a]) * prod_t'(t_s3);
			if (en_5) acc_s5[a]  <= round_q16(prod_s4[a]) + coef_c_q[a];
			if (en_6) prod_s6[a] <= prod_t'(acc_s5[a]) * prod_t'(t_s5);
			if (en_7) pt_s7[a]   <= sat32(round_q16(prod_s6[a]) + coef_d_q[a]);
		end
	end

	assign point.valid   = valid_s7;
	assign point.point_x = pt_s7[0];
	assign point.point_y = pt_s7[1];

	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !en_2 |=> valid_s1 && $stable(t_s1))
		else $error("stage 1 lost or changed a stalled sample");

	a_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> (t_s1 >= 0) && (t_s1 <= T_ONE))
		else $error("clamped t out of range");

	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && valid_s2 && valid_s3 && valid_s4 && valid_s5 && valid_s6
		&& valid_s7 && !point.ready |-> !sample.ready)
		else $error("full pipeline accepted a sample while stalled");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s6 && en_7 |=> valid_s7)
		else $error("stage 6 result dropped");

endmodule
`default_nettype wire

[tb/sv/hermite_tb_pkg.sv]
package hermite_tb_pkg;
	import chce_pkg::*;

	typedef struct packed {
		coord_t x;
		coord_t y;
	} point_t;

	class hermite_point_board;
		coord_t regs[NUM_REGS];
		longint coef[NUM_AXES][4];
		point_t points_due[$];
		int errors;
		int checked;

		function new();
			foreach (regs[i]) regs[i] = '0;
			form_coef();
		endfunction

		// a, b, c, d per axis, exact
		function void form_coef();
			longint p1, t1, p2, t2;
			for (int ax = 0; ax < NUM_AXES; ax++) begin
				p1 = regs[REG_START_X + ax];
				t1 = regs[REG_START_TAN_X + ax];
				p2 = regs[REG_END_X + ax];
				t2 = regs[REG_END_TAN_X + ax];
				coef[ax][0] = 2 * p1 + t1 + t2 - 2 * p2;
				coef[ax][1] = -3 * p1 - 2 * t1 - t2 + 3 * p2;
				coef[ax][2] = t1;
				coef[ax][3] = p1;
			end
		endfunction

		function void set_reg(cfg_idx_t idx, coord_t val);
			regs[idx] = val;
			form_coef();
		endfunction

		// Horner, round half up at each stage, saturate at the end
		function coord_t eval_axis(int ax, longint t);
			longint acc;
			acc = coef[ax][0];
			for (int k = 1; k < 4; k++)
				acc = ((acc * t + longint'(ROUND_HALF)) >>> FRAC_W) + coef[ax][k];
			if (acc > longint'(COORD_MAX))
				return COORD_MAX;
			if (acc < longint'(COORD_MIN))
				return COORD_MIN;
			return coord_t'(acc);
		endfunction

		function void note_param(t_t t);
			longint tc;
			point_t pt;
			tc = t;
			if (tc < 0)
				tc = 0;
			if (tc > longint'(T_ONE))
				tc = T_ONE;
			pt.x = eval_axis(0, tc);
			pt.y = eval_axis(1, tc);
			points_due.push_back(pt);
		endfunction

		function void fail(string msg);
			errors++;
			if (errors <= 10)
				$display("%s", msg);
		endfunction

		function void check_point(coord_t x, coord_t y);
			point_t want;
			if (points_due.size() == 0) begin
				fail($sformatf("unexpected point x=%0d y=%0d", x, y));
				return;
			end
			want = points_due.pop_front();
			checked++;
			if (x !== want.x)
				fail($sformatf("point_x mismatch: expected %0d, got %0d", want.x, x));
			if (y !== want.y)
				fail($sformatf("point_y mismatch: expected %0d, got %0d", want.y, y));
		endfunction

		function void check_reg(cfg_idx_t idx, logic [PDATA_W-1:0] got);
			if (got !== PDATA_W'(regs[idx]))
				fail($sformatf("%s readback: expected %h, got %h", idx.name(), regs[idx], got));
		endfunction

		function int pending();
			return points_due.size();
		endfunction
	endclass

endpackage

[tb/sv/testbench.sv]
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import chce_pkg::*;
	import hermite_tb_pkg::*;

	localparam int STALL_LIMIT = 4000;
	localparam int HOLD_CYCLES = 400;
	localparam int END_T [3] = '{-131072, 0, 65536};
	localparam int SWEEP_T [12] = '{-131072, -1, 0, 1, 16384, 32767, 32768, 49152,
		65535, 65536, 65537, 131071};
	localparam int SAT_T [4] = '{0, 21845, 43690, 65536};

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic pready;

	chce_sample_if sample();
	chce_point_if  point();

	cubic_hermite_curve_eval DUT (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.sample(sample),
		.point(point)
	);

	hermite_point_board board = new();
	bit quiet = 1'b1;
	bit hold_req = 1'b0;
	int idle_cycles = 0;
	int params_taken = 0;
	int settings = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			idle_cycles++;
			if (sample.valid && sample.ready) begin
				board.note_param(sample.param_t);
				params_taken++;
				idle_cycles = 0;
			end
			if (point.valid && point.ready) begin
				board.check_point(point.point_x, point.point_y);
				idle_cycles = 0;
			end
			if (psel && penable && pready)
				idle_cycles = 0;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("watchdog: no request moved for %0d cycles, %0d points outstanding",
					STALL_LIMIT, board.pending());
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	// output side: random stalls, one long hold-off on request
	initial begin
		bit hold_done;
		hold_done = 1'b0;
		point.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_req && !hold_done) begin
				point.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_done = 1'b1;
				point.ready <= 1'b1;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				point.ready <= 1'b0;
				repeat ($urandom_range(1, 17)) @(posedge clk);
				point.ready <= 1'b1;
			end else begin
				point.ready <= 1'b1;
			end
		end
	end

	task automatic apb_access(bit wr, cfg_idx_t idx, coord_t val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		if (wr)
			board.set_reg(idx, val);
		else
			board.check_reg(idx, prdata);
	endtask

	task automatic set_curve(coord_t sx, sy, stx, sty, ex, ey, etx, ety);
		coord_t vals[NUM_REGS];
		vals = '{sx, sy, stx, sty, ex, ey, etx, ety};
		for (int i = 0; i < NUM_REGS; i++)
			apb_access(1'b1, cfg_idx_t'(i), vals[i]);
		for (int i = 0; i < NUM_REGS; i++)
			apb_access(1'b0, cfg_idx_t'(i), '0);
		settings++;
	endtask

	task automatic send_param(t_t t);
		if (!quiet && $urandom_range(0, 7) == 0) begin
			sample.valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		sample.valid <= 1'b1;
		sample.param_t <= t;
		do @(posedge clk); while (!sample.ready);
	endtask

	// stop offering and drain all outstanding points
	task automatic finish_phase();
		sample.valid <= 1'b0;
		@(posedge clk);
		while (board.pending() != 0)
			@(posedge clk);
	endtask

	function automatic t_t rand_param();
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: return t_t'($urandom_range(0, 65536));
			5, 6: return t_t'($urandom);
			7: return t_t'(int'($urandom_range(0, 4)) - 2);
			8: return t_t'(int'($urandom_range(0, 4)) + 65534);
			default: return $urandom_range(0, 1) ? t_t'(-131072) : t_t'(131071);
		endcase
	endfunction

	function automatic coord_t rand_coord();
		case ($urandom_range(0, 7))
			0: return COORD_MAX;
			1: return COORD_MIN;
			2, 3: return coord_t'($urandom);
			default: return coord_t'(int'($urandom_range(0, 1 << 21)) - (1 << 20));
		endcase
	endfunction

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		sample.valid = 1'b0;
		sample.param_t = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// coefficients straight out of reset
		foreach (END_T[i])
			send_param(t_t'(END_T[i]));
		finish_phase();

		set_curve(98304, -131072, 196608, 65536, -262144, 655360, 32768, -458752);
		foreach (SWEEP_T[i])
			send_param(t_t'(SWEEP_T[i]));
		finish_phase();

		// x runs off the top, y off the bottom
		set_curve(COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN,
			COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN);
		foreach (SAT_T[i])
			send_param(t_t'(SAT_T[i]));
		finish_phase();

		set_curve(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN,
			COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN);
		foreach (SAT_T[i])
			send_param(t_t'(SAT_T[i]));
		finish_phase();

		for (int ph = 0; ph < 10; ph++) begin
			quiet = (ph == 5 || ph >= 8);
			set_curve(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
				rand_coord(), rand_coord(), rand_coord(), rand_coord());
			if (ph == 3)
				hold_req = 1'b1;
			repeat (100)
				send_param(rand_param());
			finish_phase();
		end

		repeat (16) @(posedge clk);
		$display("Checked %0d points from %0d samples over %0d curve settings,",
			board.checked, params_taken, settings);
		$display("with clamped t, saturated outputs, random gaps and a long output hold-off.");
		if (board.errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
